// ===== design/fssr_pkg.sv =====
// Shared types, codes and constants of the fan speed step regulator.
`timescale 1ns / 1ps
`default_nettype none

package fssr_pkg;

    // Operation codes carried in s_tuser.
    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_RPM_LOWER   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RPM_UPPER   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DUTY_FULL   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEAD_BAND   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_PCT    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOW_PCT     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_RETRY       = 3'd6;
    localparam int unsigned CFG_DATA_W = 16;

    // Register reset values.
    localparam logic [15:0] RST_RPM_LOWER = 16'd7500;
    localparam logic [15:0] RST_RPM_UPPER = 16'd38600;
    localparam logic [7:0]  RST_DUTY_FULL = 8'd100;
    localparam logic [9:0]  RST_DEAD_BAND = 10'd50;
    localparam logic [6:0]  RST_STEP_PCT  = 7'd5;
    localparam logic [6:0]  RST_LOW_PCT   = 7'd10;
    localparam logic [4:0]  RST_RETRY     = 5'd20;

    // Division by 100 as multiplication by ceil(2^19/100), exact below 43690.
    localparam int unsigned PCT_SHIFT = 19;
    localparam logic [12:0] PCT_RECIP = 13'd5243;

    // Cycles for the scale unit to settle after a configuration write.
    localparam logic [1:0] SCALE_SETTLE = 2'd2;

    // Result status codes.
    typedef enum logic [3:0] {
        ST_ADJUSTING = 4'd0,
        ST_SETTLED   = 4'd1,
        ST_MIN       = 4'd2,
        ST_MAX       = 4'd3,
        ST_REVERSAL  = 4'd4,
        ST_REJECTED  = 4'd5,
        ST_TACH_ERR  = 4'd6,
        ST_RETRY_OUT = 4'd7,
        ST_IDLE      = 4'd8
    } status_t;

    typedef struct packed {
        logic        run_active;
        logic [15:0] goal_rpm;
        logic [7:0]  duty_now;
        logic [7:0]  duty_before;
        logic        first_step;
        logic        rising;
        logic        hit_low;
        logic        hit_high;
        logic [4:0]  tries_left;
    } run_state_t;

    typedef struct packed {
        logic [15:0] rpm_lower;
        logic [15:0] rpm_upper;
        logic [7:0]  duty_full;
        logic [9:0]  dead_band;
        logic [4:0]  retry_budget;
        logic [8:0]  step;
        logic [8:0]  low_thr;
    } reg_cfg_t;

    typedef struct packed {
        logic [7:0] duty_out;
        logic       duty_write;
        status_t    status;
        logic       done_res;
    } result_t;

endpackage

`default_nettype wire

// ===== design/fssr_scale.sv =====
// Scale unit: duty step and low threshold as percentages of the full-scale duty.
`timescale 1ns / 1ps
`default_nettype none

module fssr_scale (
    input  wire logic       aclk,
    input  wire logic [7:0] duty_full,
    input  wire logic [6:0] step_pct,
    input  wire logic [6:0] low_pct,
    output logic      [8:0] step,
    output logic      [8:0] low_thr
);

    logic [14:0] step_prod_reg;
    logic [14:0] thr_prod_reg;
    logic [27:0] step_quot;
    logic [27:0] thr_quot;
    logic [8:0]  step_reg;
    logic [8:0]  low_thr_reg;

    // Percent products first, then the divide by 100 from the registered products.
    assign step_quot = {13'd0, step_prod_reg} * {15'd0, fssr_pkg::PCT_RECIP};
    assign thr_quot  = {13'd0, thr_prod_reg} * {15'd0, fssr_pkg::PCT_RECIP};

    always_ff @(posedge aclk) begin
        step_prod_reg <= {8'd0, step_pct} * {7'd0, duty_full};
        thr_prod_reg  <= {8'd0, low_pct} * {7'd0, duty_full};
        step_reg      <= step_quot[fssr_pkg::PCT_SHIFT +: 9];
        low_thr_reg   <= thr_quot[fssr_pkg::PCT_SHIFT +: 9];
    end

    assign step    = step_reg;
    assign low_thr = low_thr_reg;

endmodule

`default_nettype wire

// ===== design/fssr_core.sv =====
// Decision logic: one word and the run state give the result and the next run state.
`timescale 1ns / 1ps
`default_nettype none

module fssr_core (
    input  wire fssr_pkg::run_state_t st,
    input  wire fssr_pkg::reg_cfg_t   cfg,
    input  wire logic                 operation,
    input  wire logic [15:0]          target_rpm,
    input  wire logic [7:0]           initial_duty,
    input  wire logic [15:0]          measured_rpm,
    input  wire logic                 sample_ok,
    output fssr_pkg::run_state_t      nxt,
    output fssr_pkg::result_t         res
);

    logic [16:0] hi_band;
    logic [15:0] lo_band;
    logic [8:0]  dn_diff;
    logic [7:0]  dn_duty;
    logic [9:0]  up_sum;
    logic [7:0]  up_duty;
    logic [4:0]  tries_dec;
    logic [7:0]  cand;
    logic        stepped;
    logic        going_up;

    always_comb begin
        hi_band   = {1'b0, st.goal_rpm} + {7'd0, cfg.dead_band};
        lo_band   = (st.goal_rpm > {6'd0, cfg.dead_band}) ?
                    (st.goal_rpm - {6'd0, cfg.dead_band}) : 16'd0;
        dn_diff   = {1'b0, st.duty_now} - cfg.step;
        dn_duty   = ({1'b0, st.duty_now} > cfg.step) ? dn_diff[7:0] : 8'd0;
        up_sum    = {2'b00, st.duty_now} + {1'b0, cfg.step};
        up_duty   = (up_sum > 10'd255) ? 8'd255 : up_sum[7:0];
        tries_dec = st.tries_left - 5'd1;
        cand      = st.duty_now;
        stepped   = 1'b0;
        going_up  = 1'b0;

        nxt = st;
        res.duty_out   = 8'd0;
        res.duty_write = 1'b0;
        res.status     = fssr_pkg::ST_IDLE;
        res.done_res   = 1'b0;

        if (operation == fssr_pkg::OP_START) begin
            if (target_rpm < cfg.rpm_lower || target_rpm > cfg.rpm_upper) begin
                res.status   = fssr_pkg::ST_REJECTED;
                res.done_res = 1'b1;
            end else begin
                nxt.run_active  = 1'b1;
                nxt.goal_rpm    = target_rpm;
                nxt.duty_now    = initial_duty;
                nxt.duty_before = 8'd0;
                nxt.first_step  = 1'b1;
                nxt.rising      = 1'b0;
                nxt.hit_low     = 1'b0;
                nxt.hit_high    = 1'b0;
                nxt.tries_left  = cfg.retry_budget;
                if (cfg.retry_budget == 5'd0) begin
                    res.status   = fssr_pkg::ST_RETRY_OUT;
                    res.done_res = 1'b1;
                end else begin
                    res.status = fssr_pkg::ST_ADJUSTING;
                end
            end
        end else if (st.run_active) begin
            nxt.tries_left = tries_dec;
            if (!sample_ok) begin
                // Put back the duty that was in force before the last step.
                nxt.duty_now   = st.duty_before;
                res.duty_out   = st.duty_before;
                res.duty_write = 1'b1;
                res.status     = fssr_pkg::ST_TACH_ERR;
                res.done_res   = 1'b1;
            end else begin
                nxt.duty_before = st.duty_now;
                if ({1'b0, measured_rpm} > hi_band) begin
                    // Too fast: step down, or note the minimum duty.
                    if ({1'b0, st.duty_now} <= cfg.low_thr) begin
                        if (st.hit_low) begin
                            res.status   = fssr_pkg::ST_MIN;
                            res.done_res = 1'b1;
                        end else begin
                            nxt.hit_low = 1'b1;
                            stepped     = 1'b1;
                        end
                    end else begin
                        cand    = dn_duty;
                        stepped = 1'b1;
                    end
                end else if (measured_rpm < lo_band) begin
                    // Too slow: step up, or note the full duty.
                    if (st.duty_now >= cfg.duty_full) begin
                        if (st.hit_high) begin
                            res.status   = fssr_pkg::ST_MAX;
                            res.done_res = 1'b1;
                        end else begin
                            nxt.hit_high = 1'b1;
                            stepped      = 1'b1;
                        end
                    end else begin
                        cand    = up_duty;
                        stepped = 1'b1;
                    end
                end else begin
                    res.status   = fssr_pkg::ST_SETTLED;
                    res.done_res = 1'b1;
                end

                if (stepped) begin
                    // An unchanged duty counts as a step down.
                    going_up = st.duty_now < cand;
                    if (!st.first_step && (going_up != st.rising)) begin
                        nxt.duty_now   = st.duty_now;
                        res.duty_out   = st.duty_now;
                        res.duty_write = 1'b1;
                        res.status     = fssr_pkg::ST_REVERSAL;
                        res.done_res   = 1'b1;
                    end else begin
                        nxt.rising     = going_up;
                        nxt.first_step = 1'b0;
                        nxt.duty_now   = cand;
                        res.duty_out   = cand;
                        res.duty_write = 1'b1;
                        if (tries_dec == 5'd0) begin
                            res.status   = fssr_pkg::ST_RETRY_OUT;
                            res.done_res = 1'b1;
                        end else begin
                            res.status = fssr_pkg::ST_ADJUSTING;
                        end
                    end
                end
            end
        end

        if (res.done_res) begin
            nxt.run_active = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== design/fan_speed_step_regulator.sv =====
// Top level of the fan speed step regulator: stream ports, registers and run state.
`timescale 1ns / 1ps
`default_nettype none

// The regulator takes one word per clock while the result stream is not stalled and
// the scale unit has settled, and returns exactly one result word for each. A start
// word (s_tuser low) opens a run toward target_rpm from initial_duty, or is rejected
// when the target lies outside the configured RPM limits; each sample word (s_tuser
// high) then moves the duty at most one step, toward the target unless the sample
// failed, and reports whether the duty must be programmed and whether the run has
// ended (m_tlast). A word passes through the input register and then the result
// register; the decision for a word is made in a single pass of compare-and-step
// logic that also updates the run state, so consecutive words see each other's
// effects in order. The duty step and the low duty threshold are percentages of the
// full-scale duty, recomputed by a two-stage scale unit; after any configuration write,
// words are held in the input register while that unit settles. Configuration
// should be written only while no word is in flight.
module fan_speed_step_regulator (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input stream.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata: target_rpm[15:0], initial_duty[23:16], measured_rpm[39:24],
    // sample_ok[40], zero fill [47:41].
    input  wire logic [47:0]                     s_tdata,
    // s_tuser: operation (0 start a run, 1 tach sample).
    input  wire logic                            s_tuser,
    // Result stream.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata: duty_out[7:0], duty_write[8], status[12:9], zero fill [15:13].
    output logic [15:0]                          m_tdata,
    // m_tlast: done_res, the run has ended.
    output logic                                 m_tlast,
    // Configuration write port.
    input  wire logic                            cfg_wr_en,
    input  wire logic [fssr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [fssr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers.
    logic [15:0] rpm_lower_reg;
    logic [15:0] rpm_upper_reg;
    logic [7:0]  duty_full_reg;
    logic [9:0]  dead_band_reg;
    logic [6:0]  step_pct_reg;
    logic [6:0]  low_pct_reg;
    logic [4:0]  retry_reg;
    logic [1:0]  settle_reg;
    logic [1:0]  settle_next;

    // Input register.
    logic        in_valid_reg;
    logic        op_reg;
    logic [15:0] target_reg;
    logic [7:0]  init_reg;
    logic [15:0] meas_reg;
    logic        ok_reg;

    // Result register.
    logic                 out_valid_reg;
    fssr_pkg::result_t    res_reg;

    // Run state.
    fssr_pkg::run_state_t state_reg;
    fssr_pkg::run_state_t state_next;
    fssr_pkg::result_t    core_res;
    fssr_pkg::reg_cfg_t   cfg;

    logic [8:0] step;
    logic [8:0] low_thr;
    logic       out_free;
    logic       fire;
    logic       in_take;

    // A word is decided when the result register can take it and the scale
    // unit has settled; the input register refills in the same cycle.
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free && (settle_reg == 2'd0);
    assign s_tready = !in_valid_reg || fire;
    assign in_take  = s_tvalid && s_tready;

    assign settle_next = cfg_wr_en ? fssr_pkg::SCALE_SETTLE :
                         (settle_reg != 2'd0) ? (settle_reg - 2'd1) : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rpm_lower_reg <= fssr_pkg::RST_RPM_LOWER;
            rpm_upper_reg <= fssr_pkg::RST_RPM_UPPER;
            duty_full_reg <= fssr_pkg::RST_DUTY_FULL;
            dead_band_reg <= fssr_pkg::RST_DEAD_BAND;
            step_pct_reg  <= fssr_pkg::RST_STEP_PCT;
            low_pct_reg   <= fssr_pkg::RST_LOW_PCT;
            retry_reg     <= fssr_pkg::RST_RETRY;
            settle_reg    <= fssr_pkg::SCALE_SETTLE;
        end else begin
            settle_reg <= settle_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    fssr_pkg::CFG_RPM_LOWER: rpm_lower_reg <= cfg_wdata;
                    fssr_pkg::CFG_RPM_UPPER: rpm_upper_reg <= cfg_wdata;
                    fssr_pkg::CFG_DUTY_FULL: duty_full_reg <= cfg_wdata[7:0];
                    fssr_pkg::CFG_DEAD_BAND: dead_band_reg <= cfg_wdata[9:0];
                    fssr_pkg::CFG_STEP_PCT:  step_pct_reg  <= cfg_wdata[6:0];
                    fssr_pkg::CFG_LOW_PCT:   low_pct_reg   <= cfg_wdata[6:0];
                    fssr_pkg::CFG_RETRY:     retry_reg     <= cfg_wdata[4:0];
                    default: ;
                endcase
            end
        end
    end

    fssr_scale u_scale (
        .aclk      (aclk),
        .duty_full (duty_full_reg),
        .step_pct  (step_pct_reg),
        .low_pct   (low_pct_reg),
        .step      (step),
        .low_thr   (low_thr)
    );

    always_comb begin
        cfg.rpm_lower    = rpm_lower_reg;
        cfg.rpm_upper    = rpm_upper_reg;
        cfg.duty_full    = duty_full_reg;
        cfg.dead_band    = dead_band_reg;
        cfg.retry_budget = retry_reg;
        cfg.step         = step;
        cfg.low_thr      = low_thr;
    end

    fssr_core u_core (
        .st           (state_reg),
        .cfg          (cfg),
        .operation    (op_reg),
        .target_rpm   (target_reg),
        .initial_duty (init_reg),
        .measured_rpm (meas_reg),
        .sample_ok    (ok_reg),
        .nxt          (state_next),
        .res          (core_res)
    );

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            state_reg.run_active <= 1'b0;
            state_reg.goal_rpm   <= 16'd0;
            state_reg.duty_now   <= 8'd0;
            state_reg.duty_before <= 8'd0;
            state_reg.first_step <= 1'b1;
            state_reg.rising     <= 1'b0;
            state_reg.hit_low    <= 1'b0;
            state_reg.hit_high   <= 1'b0;
            state_reg.tries_left <= 5'd0;
        end else begin
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            op_reg     <= s_tuser;
            target_reg <= s_tdata[15:0];
            init_reg   <= s_tdata[23:16];
            meas_reg   <= s_tdata[39:24];
            ok_reg     <= s_tdata[40];
        end
        if (fire) begin
            res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, res_reg.status, res_reg.duty_write, res_reg.duty_out};
    assign m_tlast  = res_reg.done_res;

    // A result that ends the run leaves no run active behind it.
    a_done_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && core_res.done_res |=> !state_reg.run_active)
        else $error("run still active after a result that ended it");

    // A sample with no run active leaves the run state untouched.
    a_idle_sample_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (op_reg == fssr_pkg::OP_SAMPLE) && !state_reg.run_active
        |=> state_reg == $past(state_reg))
        else $error("idle sample changed the run state");

    // The duty field is zero whenever no duty write is requested.
    a_unused_duty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !res_reg.duty_write |-> res_reg.duty_out == 8'd0)
        else $error("duty field set without a duty write");

    // An idle report never ends a run.
    a_idle_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (res_reg.status == fssr_pkg::ST_IDLE) |-> !res_reg.done_res)
        else $error("idle status reported as end of run");

endmodule

`default_nettype wire
